// File: rtl/core/mfu_pkg.sv
// Shared constants, types and helpers for the MFU page replacement block.
package mfu_pkg;

   localparam int FRAMES = 8;
   localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int PAGE_W = 16;
   localparam int CNT_W  = 16;
   localparam int CFG_W  = 4;
   localparam int SLOT_W = 3;
   localparam int LIM_W  = CFG_W + FIDX_W + 1;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;
   localparam logic [CNT_W-1:0] CNT_MAX   = '1;

   typedef enum logic [1:0] {
      MFU_IDLE,
      MFU_SCAN,
      MFU_DONE
   } mfu_state_type;

   typedef struct packed {
      logic               valid;
      logic [PAGE_W-1:0]  page;
      logic [CNT_W-1:0]   uses;
   } frame_rd_type;

   typedef struct packed {
      logic               en;
      logic               clear;
      logic [FIDX_W-1:0]  idx;
      logic [PAGE_W-1:0]  page;
      logic [CNT_W-1:0]   uses;
   } frame_wr_type;

   typedef struct packed {
      logic               valid;
      logic               hit;
      logic               evict;
      logic [FIDX_W-1:0]  idx;
      logic [PAGE_W-1:0]  page;
      logic [PAGE_W-1:0]  evict_page;
      logic [CNT_W-1:0]   hit_uses;
   } decide_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_bits(input logic [FIDX_W-1:0] idx);
      logic [FIDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// File: rtl/core/mfu_frame_table.sv
// Frame store: valid bits, page numbers and use counts, one read and one write port.
module mfu_frame_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [mfu_pkg::FIDX_W-1:0]         rd_idx,
   output mfu_pkg::frame_rd_type              rd,
   input  mfu_pkg::frame_wr_type              wr
);

   logic [mfu_pkg::FRAMES-1:0] valid_ff;
   logic [mfu_pkg::FRAMES-1:0] valid_in;
   logic [mfu_pkg::PAGE_W-1:0] page_ff [mfu_pkg::FRAMES];
   logic [mfu_pkg::CNT_W-1:0]  uses_ff [mfu_pkg::FRAMES];

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = 1'b1;
      end
      if (wr.clear) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         page_ff[wr.idx] <= wr.page;
         uses_ff[wr.idx] <= wr.uses;
      end
   end

   assign rd.valid = valid_ff[rd_idx];
   assign rd.page  = page_ff[rd_idx];
   assign rd.uses  = uses_ff[rd_idx];

endmodule

// File: rtl/core/mfu_scan_unit.sv
// Frame scan sequencer: one frame compared per cycle for hit, empty slot and victim.
module mfu_scan_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mfu_pkg::PAGE_W-1:0]         page,
   input  logic [mfu_pkg::FIDX_W-1:0]         last_idx,
   input  logic                               commit,
   output logic                               idle,
   output logic [mfu_pkg::FIDX_W-1:0]         rd_idx,
   input  mfu_pkg::frame_rd_type              rd,
   output mfu_pkg::decide_type                dec
);

   mfu_pkg::mfu_state_type     state_ff, state_in;
   logic [mfu_pkg::FIDX_W-1:0] k_ff, k_in;
   logic [mfu_pkg::PAGE_W-1:0] page_ff, page_in;
   logic                       hit_ff, hit_in;
   logic [mfu_pkg::FIDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [mfu_pkg::CNT_W-1:0]  hit_uses_ff, hit_uses_in;
   logic                       empty_ff, empty_in;
   logic [mfu_pkg::FIDX_W-1:0] empty_idx_ff, empty_idx_in;
   logic [mfu_pkg::FIDX_W-1:0] best_idx_ff, best_idx_in;
   logic [mfu_pkg::CNT_W-1:0]  best_uses_ff, best_uses_in;
   logic [mfu_pkg::PAGE_W-1:0] best_page_ff, best_page_in;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      page_in      = page_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_uses_in  = hit_uses_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      best_idx_in  = best_idx_ff;
      best_uses_in = best_uses_ff;
      best_page_in = best_page_ff;
      unique case (state_ff)
         mfu_pkg::MFU_IDLE: begin
            if (start) begin
               page_in  = page;
               k_in     = '0;
               hit_in   = 1'b0;
               empty_in = 1'b0;
               state_in = mfu_pkg::MFU_SCAN;
            end
         end
         mfu_pkg::MFU_SCAN: begin
            if (rd.valid && (rd.page == page_ff)) begin
               hit_in      = 1'b1;
               hit_idx_in  = k_ff;
               hit_uses_in = rd.uses;
               state_in    = mfu_pkg::MFU_DONE;
            end else begin
               if (!rd.valid && !empty_ff) begin
                  empty_in     = 1'b1;
                  empty_idx_in = k_ff;
               end
               if ((k_ff == '0) || (rd.uses > best_uses_ff)) begin
                  best_idx_in  = k_ff;
                  best_uses_in = rd.uses;
                  best_page_in = rd.page;
               end
               if (k_ff == last_idx) begin
                  state_in = mfu_pkg::MFU_DONE;
               end else begin
                  k_in = k_ff + mfu_pkg::FIDX_W'(1);
               end
            end
         end
         mfu_pkg::MFU_DONE: begin
            if (commit) begin
               state_in = mfu_pkg::MFU_IDLE;
            end
         end
         default: begin
            state_in = mfu_pkg::MFU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfu_pkg::MFU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      page_ff      <= page_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_uses_ff  <= hit_uses_in;
      empty_ff     <= empty_in;
      empty_idx_ff <= empty_idx_in;
      best_idx_ff  <= best_idx_in;
      best_uses_ff <= best_uses_in;
      best_page_ff <= best_page_in;
   end

   assign idle   = (state_ff == mfu_pkg::MFU_IDLE);
   assign rd_idx = k_ff;

   assign dec.valid      = (state_ff == mfu_pkg::MFU_DONE);
   assign dec.hit        = hit_ff;
   assign dec.evict      = !hit_ff && !empty_ff;
   assign dec.idx        = hit_ff ? hit_idx_ff : (empty_ff ? empty_idx_ff : best_idx_ff);
   assign dec.page       = page_ff;
   assign dec.evict_page = best_page_ff;
   assign dec.hit_uses   = hit_uses_ff;

endmodule

// File: rtl/core/mfu_page_replacement.sv
// Top level of the MFU page replacement block: totals, frame update and result register.
//
//   channel   dir  handshake             payload
//   req_*     in   tvalid/tready         tdata page_number, tlast last_reference
//   rsp_*     out  tvalid/tready         tdata slot/evict/totals, tuser fault, tlast done
//   csr_*     in   write enable only     frames_in_use
//
// A request passes through an accept step, a scan of the active frames one by one in the
// shared compare unit (stopping at a hit), and a commit.
// Reset clears the valid bits and totals at once; no clearing pass.
// Commit stalls while the result register holds an untaken response.
module mfu_page_replacement (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,   // [15:0] page_number
   input  logic                       req_tlast,   // last_reference
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [55:0]                rsp_tdata,   // [2:0] frame_slot, [3] evicted_valid,
                                                   // [19:4] evicted_page, [35:20] fault_total,
                                                   // [51:36] hit_total, [55:52] zero
   output logic                       rsp_tuser,   // fault_flag
   output logic                       rsp_tlast,   // string_done
   input  logic                       csr_write_enable,
   input  logic [3:0]                 csr_write_data
);

   logic [mfu_pkg::CFG_W-1:0]  frames_ff;
   logic [mfu_pkg::LIM_W-1:0]  cfg_ext;
   logic [mfu_pkg::LIM_W-1:0]  lim;
   logic [mfu_pkg::FIDX_W-1:0] last_idx;
   logic                       last_ff, last_in;
   logic [mfu_pkg::CNT_W-1:0]  faults_ff, faults_in;
   logic [mfu_pkg::CNT_W-1:0]  hits_ff, hits_in;
   logic [mfu_pkg::CNT_W-1:0]  fault_next, hit_next;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [55:0]                rsp_data_ff, rsp_data_in;
   logic                       rsp_user_ff, rsp_user_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       accept;
   logic                       commit;
   logic                       idle;
   logic [mfu_pkg::FIDX_W-1:0] rd_idx;
   mfu_pkg::frame_rd_type      rd;
   mfu_pkg::frame_wr_type      wr;
   mfu_pkg::decide_type        dec;

   assign cfg_ext = mfu_pkg::LIM_W'(frames_ff);
   always_comb begin
      priority if (frames_ff == '0) begin
         lim = '0;
      end else if (cfg_ext > mfu_pkg::LIM_W'(mfu_pkg::FRAMES)) begin
         lim = mfu_pkg::LIM_W'(mfu_pkg::FRAMES - 1);
      end else begin
         lim = cfg_ext - mfu_pkg::LIM_W'(1);
      end
   end
   assign last_idx = lim[mfu_pkg::FIDX_W-1:0];

   assign req_tready = idle;
   assign accept     = req_tvalid && idle;
   assign commit     = dec.valid && (!rsp_valid_ff || rsp_tready);

   mfu_frame_table u_table (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (rd_idx),
      .rd     (rd),
      .wr     (wr)
   );

   mfu_scan_unit u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .page     (req_tdata),
      .last_idx (last_idx),
      .commit   (commit),
      .idle     (idle),
      .rd_idx   (rd_idx),
      .rd       (rd),
      .dec      (dec)
   );

   assign fault_next = dec.hit ? faults_ff : mfu_pkg::sat_inc(faults_ff);
   assign hit_next   = dec.hit ? mfu_pkg::sat_inc(hits_ff) : hits_ff;

   always_comb begin
      wr.en    = commit;
      wr.clear = commit && last_ff;
      wr.idx   = dec.idx;
      wr.page  = dec.page;
      wr.uses  = dec.hit ? mfu_pkg::sat_inc(dec.hit_uses) : mfu_pkg::CNT_W'(1);
   end

   always_comb begin
      last_in      = accept ? req_tlast : last_ff;
      faults_in    = faults_ff;
      hits_in      = hits_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         faults_in    = last_ff ? '0 : fault_next;
         hits_in      = last_ff ? '0 : hit_next;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, hit_next, fault_next,
                         dec.evict ? dec.evict_page : mfu_pkg::PAGE_W'(0),
                         dec.evict, mfu_pkg::slot_bits(dec.idx)};
         rsp_user_in  = !dec.hit;
         rsp_last_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= mfu_pkg::CFG_RESET;
         faults_ff    <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            frames_ff <= csr_write_data;
         end
         faults_ff    <= faults_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready while a request is in progress");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> rsp_tuser)
      else $error("eviction reported on a hit");

   a_totals_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[35:20] != 16'd0) || (rsp_tdata[51:36] != 16'd0)))
      else $error("response totals both zero");
`endif

endmodule
